// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the receiver RTL, used by the engine.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== hw/rtl/mbrx_pkg.sv =====
// Types, codes and the CRC-16 step for the Modbus RTU frame receiver.
// No dependencies; imported by the receiver engine, the top level and the bench.
`timescale 1ns / 1ps

package mbrx_pkg;

  typedef enum logic [1:0] {
    REQ_RX   = 2'd0,
    REQ_TICK = 2'd1,
    REQ_TX   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_ADDR_MISS = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_EXC_CODE   = 2'd2
  } cfg_idx_e;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_TX      = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_ERR_FLAG = 8'h80;
  localparam int unsigned MIN_FRAME_BYTES = 4;

  // Error reply byte positions
  localparam int unsigned ERR_IDX_ADDR = 0;
  localparam int unsigned ERR_IDX_FUNC = 1;
  localparam int unsigned ERR_IDX_EXC  = 2;
  localparam int unsigned ERR_IDX_CRCL = 3;
  localparam int unsigned ERR_IDX_LAST = 4;

  localparam logic [7:0]  RST_SLAVE_ADDR = 8'h01;
  localparam logic [15:0] RST_TIMEOUT    = 16'h0004;
  localparam logic [7:0]  RST_EXC_CODE   = 8'h04;

  typedef struct packed {
    logic [7:0]  own_addr;
    logic [15:0] frame_timeout_ticks;
    logic [7:0]  exception_code;
  } cfg_t;

  typedef struct packed {
    logic        has;
    logic        out_kind;
    logic [2:0]  frame_status;
    logic [7:0]  tx_byte;
    logic        tx_last;
  } res_t;

  // One byte of the reflected CRC-16
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mbrx_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// No dependencies; used by the receiver top level.
`timescale 1ns / 1ps

interface mbrx_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface mbrx_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [2:0] frame_status;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, out_kind, frame_status, tx_byte, tx_last, input ready);
  modport sink   (input valid, out_kind, frame_status, tx_byte, tx_last, output ready);
endinterface

// ===== hw/rtl/mbrx_store.sv =====
// Frame byte store: one write port, one read port with registered data.
// Depends on nothing but the clock.
`timescale 1ns / 1ps

module mbrx_store #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mbrx_engine.sv =====
// Frame state, CRC, verdict and replies: one beat a cycle on step_i.
// Depends on mbrx_pkg, mbrx_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbrx_engine import mbrx_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [15:0]   silence_q, silence_d;
  logic [15:0]   crc_q, crc_d;
  logic          open_q, open_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   ftb_q, ftb_d;
  logic          pending_q, pending_d;
  logic          is_err_q, is_err_d;
  logic [CW-1:0] reply_idx_q, reply_idx_d;
  logic [15:0]   err_crc_q, err_crc_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_rdata;

  logic [CW-1:0] bc;
  logic [15:0]   crc_cur;
  logic [15:0]   ftb_cur;
  logic [7:0]    func_err;
  logic          last;
  status_e       status;

  // Read data always tracks the entry at the current reply index
  mbrx_store #(
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (reply_idx_d[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign func_err = ftb_q[7:0] | FUNC_ERR_FLAG;

  always_comb begin
    byte_count_d = byte_count_q;
    silence_d    = silence_q;
    crc_d        = crc_q;
    open_d       = open_q;
    ovf_d        = ovf_q;
    ftb_d        = ftb_q;
    pending_d    = pending_q;
    is_err_d     = is_err_q;
    reply_idx_d  = reply_idx_q;
    err_crc_d    = err_crc_q;
    mem_we       = 1'b0;
    mem_waddr    = byte_count_q[AW-1:0];
    res_o        = '0;
    bc           = open_q ? byte_count_q : '0;
    crc_cur      = open_q ? crc_q : CRC_INIT;
    ftb_cur      = open_q ? ftb_q : 16'h0000;
    last         = 1'b0;
    status       = ST_OK;

    if (step_i) begin
      case (req_e'(req_type_i))
        REQ_RX: begin
          if (!pending_q) begin
            open_d       = 1'b1;
            byte_count_d = bc;
            crc_d        = crc_cur;
            ftb_d        = ftb_cur;
            ovf_d        = open_q ? ovf_q : 1'b0;
            if (bc < CW'(FRAME_BYTES)) begin
              mem_we    = 1'b1;
              mem_waddr = bc[AW-1:0];
              if (bc == CW'(0)) begin
                ftb_d = {rx_byte_i, ftb_cur[7:0]};
              end else if (bc == CW'(1)) begin
                ftb_d = {ftb_cur[15:8], rx_byte_i};
              end
              crc_d        = crc16_feed(crc_cur, rx_byte_i);
              byte_count_d = bc + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            silence_d = '0;
          end
        end
        REQ_TICK: begin
          if (open_q) begin
            if (silence_q < cfg_i.frame_timeout_ticks) begin
              silence_d = silence_q + 16'd1;
            end else begin
              if (ovf_q) begin
                status = ST_OVERFLOW;
              end else if (byte_count_q < CW'(MIN_FRAME_BYTES)) begin
                status = ST_SHORT;
              end else if (ftb_q[15:8] != cfg_i.own_addr) begin
                status = ST_ADDR_MISS;
              end else if (crc_q != 16'h0000) begin
                status = ST_CRC_ERR;
              end else begin
                status = ST_OK;
              end
              open_d             = 1'b0;
              silence_d          = '0;
              pending_d          = 1'b1;
              is_err_d           = (status != ST_OK);
              reply_idx_d        = '0;
              res_o.has          = 1'b1;
              res_o.out_kind     = KIND_VERDICT;
              res_o.frame_status = status;
            end
          end
        end
        REQ_TX: begin
          if (pending_q) begin
            if (is_err_q) begin
              // Build the error CRC one byte per beat as the bytes leave
              case (reply_idx_q)
                CW'(ERR_IDX_ADDR): begin
                  res_o.tx_byte = ftb_q[15:8];
                  err_crc_d     = crc16_feed(CRC_INIT, ftb_q[15:8]);
                end
                CW'(ERR_IDX_FUNC): begin
                  res_o.tx_byte = func_err;
                  err_crc_d     = crc16_feed(err_crc_q, func_err);
                end
                CW'(ERR_IDX_EXC): begin
                  res_o.tx_byte = cfg_i.exception_code;
                  err_crc_d     = crc16_feed(err_crc_q, cfg_i.exception_code);
                end
                CW'(ERR_IDX_CRCL): res_o.tx_byte = err_crc_q[7:0];
                default:           res_o.tx_byte = err_crc_q[15:8];
              endcase
              last = (reply_idx_q >= CW'(ERR_IDX_LAST));
            end else begin
              res_o.tx_byte = mem_rdata;
              last = ({1'b0, reply_idx_q} + {{CW{1'b0}}, 1'b1}) >= {1'b0, byte_count_q};
            end
            if (last) begin
              pending_d   = 1'b0;
              reply_idx_d = '0;
            end else begin
              reply_idx_d = reply_idx_q + CW'(1);
            end
            res_o.has      = 1'b1;
            res_o.out_kind = KIND_TX;
            res_o.tx_last  = last;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      silence_q    <= '0;
      crc_q        <= CRC_INIT;
      open_q       <= 1'b0;
      ovf_q        <= 1'b0;
      ftb_q        <= '0;
      pending_q    <= 1'b0;
      is_err_q     <= 1'b0;
      reply_idx_q  <= '0;
      err_crc_q    <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      silence_q    <= silence_d;
      crc_q        <= crc_d;
      open_q       <= open_d;
      ovf_q        <= ovf_d;
      ftb_q        <= ftb_d;
      pending_q    <= pending_d;
      is_err_q     <= is_err_d;
      reply_idx_q  <= reply_idx_d;
      err_crc_q    <= err_crc_d;
    end
  end

  `ASSERT_IMP(a_open_excl_pending, clk_i, rst_ni, open_q, !pending_q,
              "frame open with reply pending")
  `ASSERT_IMP(a_echo_in_frame, clk_i, rst_ni, pending_q && !is_err_q,
              (byte_count_q >= CW'(MIN_FRAME_BYTES)) && (reply_idx_q < byte_count_q),
              "echo index outside frame")
  `ASSERT_IMP(a_err_idx_range, clk_i, rst_ni, pending_q && is_err_q,
              reply_idx_q <= CW'(ERR_IDX_LAST), "error reply index out of range")
  `ASSERT_NXT(a_rx_dropped, clk_i, rst_ni, step_i && pending_q && (req_type_i == REQ_RX),
              $stable(byte_count_q) && $stable(crc_q), "byte taken while reply pending")

endmodule

// ===== hw/rtl/modbus_rtu_frame_receiver.sv =====
// Top level of the Modbus RTU slave frame receiver: channel registers and config.
// Depends on mbrx_pkg, mbrx_if and mbrx_engine.
//
//  channel   dir  beat contents                                 handshake
//  req_i     in   req_type, rx_byte                             valid/ready
//  res_o     out  out_kind, frame_status, tx_byte, tx_last      valid/ready
//  cfg       in   cfg_index_i, cfg_data_i                       cfg_we_i only
//
// A request beat taken from req_i is held in the input register until the engine handles
// it, which it does once the output register is free or draining; any result it causes is
// loaded into the output register and offered on res_o from there.
// The engine handles one beat a cycle, so throughput is one beat a cycle while results drain.
// A stalled result holds the engine; the input register then holds one beat and ready drops.
// Reset clears frame and reply state and loads the register defaults.
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver import mbrx_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  mbrx_req_if.sink    req_i,
  mbrx_res_if.source  res_o
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] in_type_q;
  logic [7:0] in_byte_q;

  // Output register
  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  cfg_t       cfg_q;
  res_t       eng_res;
  logic       step;
  logic       in_take;

  // Advance the held beat when the output register is free or draining
  assign step    = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_take = req_i.valid && req_i.ready;

  assign req_i.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (in_valid_q && !step);
    out_valid_d = out_valid_q && !res_o.ready;
    if (step && eng_res.has) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= req_i.req_type;
      in_byte_q <= req_i.rx_byte;
    end
    if (step && eng_res.has) begin
      out_q <= eng_res;
    end
  end

  // Configuration registers; drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr            <= RST_SLAVE_ADDR;
      cfg_q.frame_timeout_ticks <= RST_TIMEOUT;
      cfg_q.exception_code      <= RST_EXC_CODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SLAVE_ADDR: cfg_q.own_addr            <= cfg_data_i[7:0];
        CFG_TIMEOUT:    cfg_q.frame_timeout_ticks <= cfg_data_i;
        CFG_EXC_CODE:   cfg_q.exception_code      <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  mbrx_engine #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_type_i (in_type_q),
    .rx_byte_i  (in_byte_q),
    .cfg_i      (cfg_q),
    .res_o      (eng_res)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.out_kind     = out_q.out_kind;
  assign res_o.frame_status = out_q.frame_status;
  assign res_o.tx_byte      = out_q.tx_byte;
  assign res_o.tx_last      = out_q.tx_last;

endmodule

// ===== tb/sv/tb_modbus_rtu_frame_receiver.sv =====
// Self-checking bench for the Modbus RTU frame receiver: directed table, then random frames.
// Depends on mbrx_pkg, the mbrx_req_if / mbrx_res_if channels and the receiver RTL.
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_receiver;
  import mbrx_pkg::*;

  localparam int unsigned FRAME_BYTES    = 256;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned SETTLE_CYCLES  = 8;     // input reg + engine + output reg, with margin
  localparam int unsigned LONG_HOLD      = 400;   // receiver hold-off used to back the block up
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side

  // Codes the package leaves unnamed: the spare request type and the spare register index
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_NONE   = 2'd3;

  typedef enum {SHAPE_GOOD, SHAPE_SHORT, SHAPE_JUNK, SHAPE_FULL, SHAPE_OVER} frame_shape_e;

  typedef struct packed {
    bit         has;
    logic       out_kind;
    status_e    frame_status;
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_beat_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    bit         typed;
    out_beat_t  want;
  } stim_row_t;

  localparam out_beat_t NO_BEAT = '{1'b0, KIND_VERDICT, ST_OK, 8'h00, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  mbrx_req_if req_if ();
  mbrx_res_if res_if ();

  modbus_rtu_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framer state as the bench expects it, plus its copy of the registers.
  // Updated at the rising edge on which a request beat or a register write lands.
  // ---------------------------------------------------------------------------
  logic [7:0]  cur_slave;
  logic [15:0] cur_timeout;
  logic [7:0]  cur_exc;

  logic [7:0]  rx_frame [FRAME_BYTES];
  logic [8:0]  rx_count;
  logic [15:0] quiet_ticks;
  logic [15:0] rx_crc;
  bit          frame_live;
  bit          frame_over;
  logic [7:0]  hdr_addr;
  logic [7:0]  hdr_func;
  bit          reply_owed;
  bit          reply_err;
  logic [8:0]  reply_pos;
  logic [15:0] err_crc;

  out_beat_t   out_beats_due [$];
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned frame_traffic;

  // Side band from the directed table: a row with a typed result overrides the prediction
  bit          row_typed;
  out_beat_t   row_want;
  stim_row_t   dir_rows [];

  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;

  // Reflected CRC-16, one byte at a time
  function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] d);
    c[7:0] = c[7:0] ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    end
    return c;
  endfunction

  // Advance the framer by one request beat and return the result it owes, if any
  function automatic out_beat_t advance_framer(input logic [1:0] kind, input logic [7:0] data);
    out_beat_t  o;
    logic [7:0] func_x;
    o = NO_BEAT;
    case (kind)
      REQ_RX: begin
        if (!reply_owed) begin
          if (!frame_live) begin
            frame_live = 1'b1;
            rx_count   = '0;
            rx_crc     = CRC_INIT;
            frame_over = 1'b0;
            hdr_addr   = 8'h00;
            hdr_func   = 8'h00;
          end
          if (rx_count < FRAME_BYTES) begin
            rx_frame[rx_count[7:0]] = data;
            if (rx_count == 0) hdr_addr = data;
            else if (rx_count == 1) hdr_func = data;
            rx_crc   = crc_add(rx_crc, data);
            rx_count = rx_count + 1'b1;
          end else begin
            frame_over = 1'b1;
          end
          quiet_ticks = '0;
        end
      end
      REQ_TICK: begin
        if (frame_live) begin
          if (quiet_ticks < cur_timeout) begin
            quiet_ticks = quiet_ticks + 1'b1;
          end else begin
            o.has = 1'b1;
            o.out_kind = KIND_VERDICT;
            if (frame_over) o.frame_status = ST_OVERFLOW;
            else if (rx_count < MIN_FRAME_BYTES) o.frame_status = ST_SHORT;
            else if (hdr_addr != cur_slave) o.frame_status = ST_ADDR_MISS;
            else if (rx_crc != 16'h0000) o.frame_status = ST_CRC_ERR;
            else o.frame_status = ST_OK;
            frame_live  = 1'b0;
            quiet_ticks = '0;
            reply_owed  = 1'b1;
            reply_err   = (o.frame_status != ST_OK);
            reply_pos   = '0;
          end
        end
      end
      REQ_TX: begin
        if (reply_owed) begin
          o.has = 1'b1;
          o.out_kind = KIND_TX;
          o.frame_status = ST_OK;
          if (reply_err) begin
            func_x = hdr_func | FUNC_ERR_FLAG;
            case (reply_pos)
              ERR_IDX_ADDR: o.tx_byte = hdr_addr;
              ERR_IDX_FUNC: o.tx_byte = func_x;
              ERR_IDX_EXC: begin
                // the checksum takes the exception code in force as this byte leaves
                err_crc = crc_add(crc_add(crc_add(CRC_INIT, hdr_addr), func_x), cur_exc);
                o.tx_byte = cur_exc;
              end
              ERR_IDX_CRCL: o.tx_byte = err_crc[7:0];
              default: o.tx_byte = err_crc[15:8];
            endcase
            o.tx_last = (reply_pos >= ERR_IDX_LAST);
          end else begin
            o.tx_byte = (reply_pos < FRAME_BYTES) ? rx_frame[reply_pos[7:0]] : 8'h00;
            o.tx_last = (reply_pos + 1 >= rx_count);
          end
          if (o.tx_last) begin
            reply_owed = 1'b0;
            reply_pos  = '0;
          end else begin
            reply_pos = reply_pos + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic out_beat_t verdict_beat(input status_e s);
    return '{1'b1, KIND_VERDICT, s, 8'h00, 1'b0};
  endfunction

  function automatic out_beat_t tx_beat(input logic [7:0] b, input logic last);
    return '{1'b1, KIND_TX, ST_OK, b, last};
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Edge monitor: register writes and request beats feed the framer copy,
  // result beats are checked against the oldest result due.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_beat_t due;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SLAVE_ADDR: cur_slave   = cfg_data_i[7:0];
          CFG_TIMEOUT:    cur_timeout = cfg_data_i;
          CFG_EXC_CODE:   cur_exc     = cfg_data_i[7:0];
          default: ;  // spare index: the block drops the write
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        due = advance_framer(req_if.req_type, req_if.rx_byte);
        if (row_typed) due = row_want;
        if (due.has) out_beats_due.push_back(due);
      end
      if (res_if.valid && res_if.ready) begin
        if (out_beats_due.size() == 0) begin
          flag_mismatch("result beat with nothing due",
                        16'({res_if.out_kind, res_if.frame_status, res_if.tx_byte,
                             res_if.tx_last}),
                        16'h0000);
        end else begin
          due = out_beats_due.pop_front();
          if (res_if.out_kind !== due.out_kind)
            flag_mismatch("out_kind", 16'(res_if.out_kind), 16'(due.out_kind));
          if (res_if.frame_status !== due.frame_status)
            flag_mismatch("frame_status", 16'(res_if.frame_status), 16'(due.frame_status));
          if (res_if.tx_byte !== due.tx_byte)
            flag_mismatch("tx_byte", 16'(res_if.tx_byte), 16'(due.tx_byte));
          if (res_if.tx_last !== due.tx_last)
            flag_mismatch("tx_last", 16'(res_if.tx_last), 16'(due.tx_last));
        end
      end
    end
  end

  // Watchdog: give up once neither channel has moved a beat for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog: no beat for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, out_beats_due.size());
      $display("tb_modbus_rtu_frame_receiver: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready changes at the falling edge. Random stalls while gaps
  // are on; a requested hold-off keeps ready low through a long stall, set by LONG_HOLD,
  // so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else if (!gaps_on || $urandom_range(0, 3) != 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task here starts and ends on a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one beat, after a random gap, and hold it until it is taken
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.rx_byte  <= data;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Beats the block should shrug off in the current state
  task automatic send_noise();
    logic [1:0] kind;
    case ($urandom_range(0, 2))
      0: kind = REQ_UNUSED;
      1: kind = reply_owed ? REQ_RX : REQ_TX;
      default: kind = reply_owed ? REQ_TICK : REQ_UNUSED;
    endcase
    send_beat(kind, 8'($urandom));
  endtask

  // Drop valid, wait for every result due, then let the pipeline run dry
  task automatic settle();
    req_if.valid <= 1'b0;
    while (out_beats_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
  endtask

  // One frame on the line: bytes with short lulls, silence until it closes,
  // then pull the whole reply. squeeze stalls the result side during the pull.
  task automatic run_frame(input frame_shape_e shape, input bit squeeze);
    logic [7:0]  body [$];
    logic [15:0] c;
    int unsigned n;
    int unsigned lull;
    case (shape)
      SHAPE_GOOD, SHAPE_FULL: begin
        if (shape == SHAPE_GOOD && $urandom_range(0, 4) == 0) body.push_back(8'($urandom));
        else body.push_back(cur_slave);
        body.push_back(8'($urandom));
        n = (shape == SHAPE_FULL) ? FRAME_BYTES - 4 : $urandom_range(0, 8);
        repeat (n) body.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (body[i]) c = crc_add(c, body[i]);
        // flip one checksum bit now and then
        if (shape == SHAPE_GOOD && $urandom_range(0, 9) == 0)
          c = c ^ (16'd1 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
      end
      SHAPE_SHORT: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      SHAPE_JUNK:  repeat ($urandom_range(4, 10)) body.push_back(8'($urandom));
      default:     repeat (FRAME_BYTES + $urandom_range(1, 4)) body.push_back(8'($urandom));
    endcase

    // a lull never reaches the timeout, so the frame stays open
    lull = (cur_timeout < 3) ? cur_timeout : 3;
    foreach (body[i]) begin
      send_beat(REQ_RX, body[i]);
      frame_traffic++;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, lull)) begin
          send_beat(REQ_TICK, 8'($urandom));
          frame_traffic++;
        end
      end
      if ($urandom_range(0, 29) == 0) send_noise();
    end

    // silence closes the frame and brings the verdict
    while (frame_live) begin
      send_beat(REQ_TICK, 8'($urandom));
      frame_traffic++;
    end

    if (squeeze) hold_off_req = 1'b1;
    while (reply_owed) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_beat(REQ_TX, 8'($urandom));
      frame_traffic++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]   addr_set;
    logic [7:0]   exc_set;
    logic [15:0]  ticks_set;
    frame_shape_e shape;
    int unsigned  r;

    req_if.valid    = 1'b0;
    req_if.req_type = REQ_RX;
    req_if.rx_byte  = 8'h00;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_SLAVE_ADDR;
    cfg_data_i      = 16'h0000;
    row_typed       = 1'b0;
    row_want        = NO_BEAT;
    mismatches      = 0;
    stuck_cycles    = 0;
    frame_traffic   = 0;

    // framer copy starts from the reset state
    cur_slave   = RST_SLAVE_ADDR;
    cur_timeout = RST_TIMEOUT;
    cur_exc     = RST_EXC_CODE;
    rx_count    = '0;
    quiet_ticks = '0;
    rx_crc      = CRC_INIT;
    frame_live  = 1'b0;
    frame_over  = 1'b0;
    hdr_addr    = 8'h00;
    hdr_func    = 8'h00;
    reply_owed  = 1'b0;
    reply_err   = 1'b0;
    reply_pos   = '0;
    err_crc     = 16'h0000;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part runs with a timeout of one tick: two ticks close a frame.
    write_reg(CFG_TIMEOUT, 16'd1);
    cfg_we_i <= 1'b0;

    dir_rows = '{
      '{REQ_TX,     8'h00, 1'b1, NO_BEAT},              // nothing to send yet
      '{REQ_TICK,   8'hFF, 1'b1, NO_BEAT},              // no frame open
      '{REQ_UNUSED, 8'hFF, 1'b1, NO_BEAT},              // spare request type
      '{REQ_RX,     8'h01, 1'b1, NO_BEAT},              // read exception status, good CRC
      '{REQ_RX,     8'h07, 1'b1, NO_BEAT},
      '{REQ_RX,     8'h41, 1'b1, NO_BEAT},
      '{REQ_RX,     8'hE2, 1'b1, NO_BEAT},
      '{REQ_TICK,   8'h00, 1'b1, NO_BEAT},
      '{REQ_TICK,   8'h00, 1'b1, verdict_beat(ST_OK)},
      '{REQ_RX,     8'h55, 1'b1, NO_BEAT},              // dropped: reply still owed
      '{REQ_TICK,   8'h00, 1'b1, NO_BEAT},              // ignored while a reply is owed
      '{REQ_TX,     8'h00, 1'b1, tx_beat(8'h01, 1'b0)}, // echo
      '{REQ_TX,     8'hFF, 1'b1, tx_beat(8'h07, 1'b0)},
      '{REQ_TX,     8'h00, 1'b1, tx_beat(8'h41, 1'b0)},
      '{REQ_TX,     8'hFF, 1'b1, tx_beat(8'hE2, 1'b1)},
      '{REQ_RX,     8'h00, 1'b1, NO_BEAT},              // lone byte: function never arrives
      '{REQ_TICK,   8'h00, 1'b1, NO_BEAT},
      '{REQ_TICK,   8'h00, 1'b1, verdict_beat(ST_SHORT)},
      '{REQ_TX,     8'h00, 1'b1, tx_beat(8'h00, 1'b0)}, // exception reply
      '{REQ_TX,     8'h00, 1'b1, tx_beat(8'h80, 1'b0)},
      '{REQ_TX,     8'h00, 1'b1, tx_beat(RST_EXC_CODE, 1'b0)},
      '{REQ_TX,     8'hFF, 1'b0, NO_BEAT},              // CRC bytes from the framer copy
      '{REQ_TX,     8'h00, 1'b0, NO_BEAT}
    };
    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want  = dir_rows[i].want;
      send_beat(dir_rows[i].kind, dir_rows[i].data);
    end
    row_typed = 1'b0;

    // Random frames over several register settings. Each phase starts idle:
    // hold the sender until every result is in, then rewrite the registers.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          addr_set  = RST_SLAVE_ADDR;
          ticks_set = RST_TIMEOUT;
          exc_set   = RST_EXC_CODE;
        end
        1: begin
          addr_set  = 8'h00;
          ticks_set = 16'd1;
          exc_set   = 8'h00;
        end
        2: begin
          addr_set  = 8'hFF;
          ticks_set = 16'd2;
          exc_set   = 8'hFF;
        end
        default: begin
          addr_set  = 8'($urandom);
          ticks_set = 16'($urandom_range(1, 6));
          exc_set   = 8'($urandom);
        end
      endcase
      // upper data bits of the byte-wide registers are junk the block must mask
      write_reg(CFG_SLAVE_ADDR, {8'($urandom), addr_set});
      write_reg(CFG_TIMEOUT, ticks_set);
      write_reg(CFG_EXC_CODE, {8'($urandom), exc_set});
      write_reg(CFG_NONE, 16'($urandom));
      cfg_we_i <= 1'b0;

      // a full store echoed under a long result stall, then a frame that overruns it
      if (ph == 0) begin
        gaps_on = 1'b1;
        run_frame(SHAPE_FULL, 1'b1);
        run_frame(SHAPE_OVER, 1'b0);
      end

      // every setting sees at least one frame
      do begin
        gaps_on = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 19);
        if (r < 14) shape = SHAPE_GOOD;
        else if (r < 17) shape = SHAPE_SHORT;
        else shape = SHAPE_JUNK;
        run_frame(shape, 1'b0);
      end while (frame_traffic < (ph + 1) * RANDOM_ITEMS / PHASES);
    end

    // Long timeout: one frame, closed by a full run of silent ticks
    settle();
    write_reg(CFG_TIMEOUT, 16'd30);
    cfg_we_i <= 1'b0;
    gaps_on = 1'b0;
    run_frame(SHAPE_GOOD, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("tb_modbus_rtu_frame_receiver: done, clean");
    end else begin
      $display("tb_modbus_rtu_frame_receiver: done, errors");
    end
    $finish;
  end

endmodule
